@@ design/stt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared token codes, lexer modes, result records and the constant tables
// (keywords and one-character specials) used by the tokenizer modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_WIDTH_DEFAULT       = 16;
  localparam int KEYWORD_MAX_LEN_DEFAULT = 11;
  localparam int QUEUE_DEPTH_DEFAULT     = 4;

  localparam int KEYWORD_TOTAL = 16;
  localparam int KW_CAP        = 16;
  localparam int PUNCT_COUNT   = 29;
  localparam int RECS_PER_REQ  = 3;

  localparam logic [5:0] KIND_SOF    = 6'd0;
  localparam logic [5:0] KIND_EOF    = 6'd1;
  localparam logic [5:0] KIND_WORD   = 6'd2;
  localparam logic [5:0] KIND_INT    = 6'd3;
  localparam logic [5:0] KIND_FLOAT  = 6'd4;
  localparam logic [5:0] KIND_STR    = 6'd5;
  localparam logic [5:0] KIND_CHR    = 6'd6;
  localparam logic [5:0] KIND_KEY0   = 6'd7;
  localparam logic [5:0] KIND_PUNCT0 = 6'd23;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_STR,
    MODE_CHR
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        bad;
  } rec_t;

  // One request: the results caused by one source byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]                   cnt;
    rec_t [RECS_PER_REQ-1:0]      recs;
  } req_t;

  // Keywords, left aligned, first character in the top byte.
  localparam logic [8*KW_CAP-1:0] KW_TEXT [KEYWORD_TOTAL] = '{
    {"int", 104'h0},
    {"float", 88'h0},
    {"char", 96'h0},
    {"string", 80'h0},
    {"key", 104'h0},
    {"bool", 96'h0},
    {"defun", 88'h0},
    {"return", 80'h0},
    {24'h6d686b, 104'h0},
    {32'h6d686b63, 96'h0},
    {"register", 64'h0},
    {72'h6b65795f7072657373, 56'h0},
    {88'h6b65795f72656c65617365, 40'h0},
    {"init", 96'h0},
    {"quit", 96'h0},
    {"if", 112'h0}
  };

  localparam logic [4:0] KW_LEN [KEYWORD_TOTAL] = '{
    5'd3, 5'd5, 5'd4, 5'd6, 5'd3, 5'd4, 5'd5, 5'd6,
    5'd3, 5'd4, 5'd8, 5'd9, 5'd11, 5'd4, 5'd4, 5'd2
  };

  // One-character specials; character i sits at byte PUNCT_COUNT-1-i.
  localparam logic [8*PUNCT_COUNT-1:0] PUNCT_TEXT = "`~!@#$%^&*-=+;:|,./?\n()[]{}<>";

  function automatic rec_t mk_rec(logic [5:0] kind, logic [15:0] line, logic [15:0] col,
                                  logic [15:0] len, logic bad);
    rec_t r;
    r.kind = kind;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.bad  = bad;
    return r;
  endfunction

  function automatic logic [15:0] len_inc(logic [15:0] v);
    return (v != LEN_MAX) ? v + 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

@@ design/source_text_tokenizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Source text tokenizer core
// Streams source bytes in and token results out through queue-style handshakes.
// ----------------------------------------------------------------------------
// Input: a request (byte_in, end_of_source) is taken at an edge where push is
//   high and full is low; end_of_source marks the last byte of a source, and
//   the next byte starts a new source with its own start-of-source result.
// Results: while empty is low the oldest result sits on token_kind through
//   last_of_run and leaves at an edge where pop is high; last_of_run marks the
//   final result caused by one byte.
// Path: a byte's request goes through the queue into the back end's register.
// Throughput: one byte per cycle in while full is low and one result per cycle
//   out while pop is high. A byte that causes two or three results holds the
//   back end until each is popped; the request queue of QUEUE_DEPTH entries
//   absorbs such bursts, and full rises once it holds QUEUE_DEPTH requests,
//   which a stalled receiver or a long run of multi-result bytes causes.
// Reset: rst, synchronous, empties the queue and the output stage and returns
//   the lexer to the start of a source at line 1, column 1.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core import stt_pkg::*; #(
  parameter int POS_WIDTH       = POS_WIDTH_DEFAULT,
  parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEFAULT,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  byte_in,
  input  wire logic        end_of_source,
  input  wire logic        push,
  output logic             full,
  output logic [5:0]       token_kind,
  output logic [15:0]      line_number,
  output logic [15:0]      column_number,
  output logic [15:0]      token_length,
  output logic             bad_input,
  output logic             last_of_run,
  output logic             empty,
  input  wire logic        pop
);

  logic accept;
  req_t front_req;
  req_t q_data;
  logic q_empty;
  logic q_pop;

  // A byte is taken whenever the queue has room; bytes that cause no result
  // (blanks, continued tokens, bytes after an error) push nothing.
  assign accept = push && !full;

  stt_front #(
    .POS_WIDTH      (POS_WIDTH),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .byte_in      (byte_in),
    .end_of_source(end_of_source),
    .req          (front_req)
  );

  stt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (accept && front_req.cnt != 2'd0),
    .wdata(front_req),
    .full (full),
    .pop  (q_pop),
    .rdata(q_data),
    .empty(q_empty)
  );

  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .line_number  (line_number),
    .column_number(column_number),
    .token_length (token_length),
    .bad_input    (bad_input),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire

@@ design/stt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer front end
// Holds the lexer state, classifies each accepted byte and builds the request
// of up to three results that the byte causes.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; #(
  parameter int POS_WIDTH       = POS_WIDTH_DEFAULT,
  parameter int KEYWORD_MAX_LEN = KEYWORD_MAX_LEN_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_source,
  output req_t            req
);

  localparam int IDXW = $clog2(KEYWORD_MAX_LEN);

  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_US  = 8'h5F;
  localparam logic [7:0] CH_LF  = 8'h0A;

  mode_t                 mode, mode_step, mode_next;
  logic                  sof_sent, sof_sent_next;
  logic                  halted, halted_step, halted_next;
  logic [POS_WIDTH-1:0]  cur_line, cur_line_next;
  logic [POS_WIDTH-1:0]  cur_col, cur_col_next;
  logic [POS_WIDTH-1:0]  start_line, start_line_next;
  logic [POS_WIDTH-1:0]  start_col, start_col_next;
  logic [15:0]           run_length, run_next;
  logic                  saw_point, saw_next;
  logic                  prev_bs, prev_bs_next;
  logic [7:0]            word_buf [KEYWORD_MAX_LEN];
  logic [7:0]            kw_buf [KEYWORD_MAX_LEN];

  logic is_alpha, is_digit, is_us, is_blank, word_char, num_char, starter;
  logic punct_hit;
  logic [5:0] punct_kind;
  logic taken, begin_tok, wr_en;
  logic [IDXW-1:0] wr_idx;
  logic [15:0] kw_len;
  logic [5:0] kw_kind;
  logic [7:0] quote;
  logic [1:0] n;

  // Byte classes and the write into the identifier buffer.
  always_comb begin : classify
    is_alpha  = (byte_in >= 8'h61 && byte_in <= 8'h7A) || (byte_in >= 8'h41 && byte_in <= 8'h5A);
    is_digit  = byte_in >= 8'h30 && byte_in <= 8'h39;
    is_us     = byte_in == CH_US;
    is_blank  = byte_in == 8'h09 || byte_in == 8'h0B || byte_in == 8'h0C ||
                byte_in == 8'h0D || byte_in == 8'h20;
    word_char = is_alpha || is_digit || is_us;
    num_char  = is_digit || byte_in == CH_DOT;
    starter   = byte_in == CH_DQ || byte_in == CH_SQ || is_digit || is_alpha || is_us;
    quote     = (mode == MODE_STR) ? CH_DQ : CH_SQ;
    punct_hit  = 1'b0;
    punct_kind = KIND_PUNCT0;
    for (int i = PUNCT_COUNT - 1; i >= 0; i--) begin
      if (PUNCT_TEXT[8*(PUNCT_COUNT-1-i) +: 8] == byte_in) begin
        punct_hit  = 1'b1;
        punct_kind = KIND_PUNCT0 + 6'(i);
      end
    end
    taken = !halted && ((mode == MODE_WORD && word_char) || (mode == MODE_NUM && num_char) ||
                        mode == MODE_STR || mode == MODE_CHR);
    begin_tok = !halted && !taken;
    wr_en  = (!halted && mode == MODE_WORD && word_char &&
              run_length < 16'(KEYWORD_MAX_LEN)) || (begin_tok && (is_alpha || is_us));
    wr_idx = begin_tok ? '0 : run_length[IDXW-1:0];
    // A word closed by this byte is matched as it stands; a word still open at
    // the last byte is matched with this byte included.
    if (mode == MODE_WORD && !word_char)
      kw_len = run_length;
    else if (begin_tok)
      kw_len = 16'd1;
    else
      kw_len = len_inc(run_length);
    for (int i = 0; i < KEYWORD_MAX_LEN; i++)
      kw_buf[i] = (wr_en && wr_idx == IDXW'(i)) ? byte_in : word_buf[i];
  end

  always_comb begin : keyword_match
    logic hit;
    kw_kind = KIND_WORD;
    for (int k = KEYWORD_TOTAL - 1; k >= 0; k--) begin
      hit = kw_len == 16'(KW_LEN[k]);
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k]) && kw_buf[i] != KW_TEXT[k][8*(KW_CAP-1-i) +: 8])
          hit = 1'b0;
      end
      if (hit)
        kw_kind = KIND_KEY0 + 6'(k);
    end
  end

  // Lexer mode next state.
  always_comb begin : mode_fsm
    mode_step = mode;
    if (!halted) begin
      case (mode)
        MODE_WORD: if (!word_char) mode_step = MODE_IDLE;
        MODE_NUM:  if (!num_char) mode_step = MODE_IDLE;
        MODE_STR, MODE_CHR: if (byte_in == quote && !prev_bs) mode_step = MODE_IDLE;
        default: ;
      endcase
      if (begin_tok) begin
        if (byte_in == CH_DQ)
          mode_step = MODE_STR;
        else if (byte_in == CH_SQ)
          mode_step = MODE_CHR;
        else if (is_digit)
          mode_step = MODE_NUM;
        else if (is_alpha || is_us)
          mode_step = MODE_WORD;
        else
          mode_step = MODE_IDLE;
      end
    end
    halted_step = halted || (begin_tok && !starter && !is_blank && !punct_hit);
    mode_next   = end_of_source ? MODE_IDLE : mode_step;
  end

  // Results and the rest of the lexer state.
  always_comb begin : datapath
    n               = '0;
    req.recs        = '0;
    sof_sent_next   = 1'b1;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    start_line_next = start_line;
    start_col_next  = start_col;
    run_next        = run_length;
    saw_next        = saw_point;
    prev_bs_next    = prev_bs;
    if (!sof_sent) begin
      req.recs[n] = mk_rec(KIND_SOF, '0, '0, '0, 1'b0);
      n = n + 2'd1;
    end
    if (!halted) begin
      case (mode)
        MODE_WORD: begin
          if (word_char) begin
            run_next = len_inc(run_length);
          end else begin
            req.recs[n] = mk_rec(kw_kind, 16'(start_line), 16'(start_col), run_length, 1'b0);
            n = n + 2'd1;
          end
        end
        MODE_NUM: begin
          if (num_char) begin
            run_next = len_inc(run_length);
            if (byte_in == CH_DOT)
              saw_next = 1'b1;
          end else begin
            req.recs[n] = mk_rec(saw_point ? KIND_FLOAT : KIND_INT, 16'(start_line),
                                 16'(start_col), run_length, 1'b0);
            n = n + 2'd1;
          end
        end
        MODE_STR, MODE_CHR: begin
          run_next = len_inc(run_length);
          if (byte_in == quote && !prev_bs) begin
            req.recs[n] = mk_rec((mode == MODE_STR) ? KIND_STR : KIND_CHR, 16'(start_line),
                                 16'(start_col), len_inc(run_length), 1'b0);
            n = n + 2'd1;
          end
          prev_bs_next = byte_in == CH_BS;
        end
        default: ;
      endcase
      if (begin_tok) begin
        start_line_next = cur_line;
        start_col_next  = cur_col;
        run_next        = 16'd1;
        saw_next        = 1'b0;
        prev_bs_next    = 1'b0;
        if (is_blank) begin
          run_next = '0;
        end else if (!starter) begin
          if (punct_hit)
            req.recs[n] = mk_rec(punct_kind, 16'(cur_line), 16'(cur_col), 16'd1, 1'b0);
          else
            req.recs[n] = mk_rec(KIND_SOF, 16'(cur_line), 16'(cur_col), 16'd1, 1'b1);
          n = n + 2'd1;
        end
      end
      if (byte_in == CH_LF) begin
        cur_line_next = (cur_line != '1) ? cur_line + 1'b1 : cur_line;
        cur_col_next  = POS_WIDTH'(1);
      end else begin
        cur_col_next  = (cur_col != '1) ? cur_col + 1'b1 : cur_col;
      end
    end
    halted_next = halted_step;
    if (end_of_source) begin
      if (!halted_step) begin
        case (mode_step)
          MODE_WORD: begin
            req.recs[n] = mk_rec(kw_kind, 16'(start_line_next), 16'(start_col_next),
                                 run_next, 1'b0);
            n = n + 2'd1;
          end
          MODE_NUM: begin
            req.recs[n] = mk_rec(saw_next ? KIND_FLOAT : KIND_INT, 16'(start_line_next),
                                 16'(start_col_next), run_next, 1'b0);
            n = n + 2'd1;
          end
          MODE_STR: begin
            req.recs[n] = mk_rec(KIND_STR, 16'(start_line_next), 16'(start_col_next),
                                 run_next, 1'b1);
            n = n + 2'd1;
          end
          MODE_CHR: begin
            req.recs[n] = mk_rec(KIND_CHR, 16'(start_line_next), 16'(start_col_next),
                                 run_next, 1'b1);
            n = n + 2'd1;
          end
          default: ;
        endcase
      end
      req.recs[n] = mk_rec(KIND_EOF, '0, '0, '0, 1'b0);
      n = n + 2'd1;
      // The next byte starts a fresh source.
      sof_sent_next   = 1'b0;
      halted_next     = 1'b0;
      cur_line_next   = POS_WIDTH'(1);
      cur_col_next    = POS_WIDTH'(1);
      start_line_next = '0;
      start_col_next  = '0;
      run_next        = '0;
      saw_next        = 1'b0;
      prev_bs_next    = 1'b0;
    end
    req.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      sof_sent   <= 1'b0;
      halted     <= 1'b0;
      cur_line   <= POS_WIDTH'(1);
      cur_col    <= POS_WIDTH'(1);
      start_line <= '0;
      start_col  <= '0;
      run_length <= '0;
      saw_point  <= 1'b0;
      prev_bs    <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      sof_sent   <= sof_sent_next;
      halted     <= halted_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
      run_length <= run_next;
      saw_point  <= saw_next;
      prev_bs    <= prev_bs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en)
      word_buf[wr_idx] <= byte_in;
  end

endmodule
`default_nettype wire

@@ design/stt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer request queue
// Short first-in first-out buffer of requests between front and back end.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t wdata,
  output logic      full,
  input  wire logic pop,
  output req_t      rdata,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !do_push)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      slots[wr_ptr] <= wdata;
  end

endmodule
`default_nettype wire

@@ design/stt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer back end
// Takes one request from the queue and hands its results out one per pop,
// marking the last result of each request.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire req_t  q_data,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire logic  pop,
  output logic       empty,
  output logic [5:0] token_kind,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic [15:0] token_length,
  output logic       bad_input,
  output logic       last_of_run
);

  req_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last_rec;
  logic       load;
  rec_t       rec;

  assign last_rec = idx == cur.cnt - 2'd1;
  assign load     = !q_empty && (!cur_valid || (pop && last_rec));
  assign q_pop    = load;
  assign empty    = !cur_valid;

  assign rec           = cur.recs[idx];
  assign token_kind    = rec.kind;
  assign line_number   = rec.line;
  assign column_number = rec.col;
  assign token_length  = rec.len;
  assign bad_input     = rec.bad;
  assign last_of_run   = last_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (pop && cur_valid) begin
      if (last_rec)
        cur_valid <= 1'b0;
      else
        idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load)
      cur <= q_data;
  end

endmodule
`default_nettype wire

@@ design/stt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module stt_checker import stt_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic [5:0]  token_kind,
  input wire logic [15:0] line_number,
  input wire logic [15:0] column_number,
  input wire logic [15:0] token_length,
  input wire logic        bad_input,
  input wire logic        last_of_run,
  input wire logic        empty,
  input wire logic        pop
);

  // Reset leaves nothing to read and room for input.
  a_reset_clean: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result side not empty or input full after reset");

  // A waiting result holds while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(token_kind) && $stable(token_length) &&
                          $stable(last_of_run)))
    else $error("stalled result changed");

  // End of source is always the last result of its byte and carries no position.
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_kind == KIND_EOF) |->
      (last_of_run && line_number == 16'd0 && column_number == 16'd0 &&
       token_length == 16'd0 && !bad_input))
    else $error("malformed end-of-source result");

  // An unknown byte is reported as a one-byte error.
  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_input && token_kind == KIND_SOF) |-> (token_length == 16'd1))
    else $error("unknown byte error with wrong length");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);
`default_nettype wire

@@ dv/tb_source_text_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source text tokenizer core testbench
// Feeds source texts byte by byte into the tokenizer and checks every token
// result against a cycle-free predictor of the lexer kept inside the bench.
// A short directed part covers each token kind and the error paths, and the
// rest is randomly built source text with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer_core;
  import stt_pkg::*;

  // Characters that steer the lexer.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_GRAVE  = 8'h60;

  // Only this many leading identifier bytes are kept for the keyword match.
  localparam int WORD_KEEP = 11;
  localparam int SPECIAL_TOTAL = 29;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        bad;
    logic        last;
  } token_t;

  logic        clk;
  logic        rst = 1'b1;
  logic [7:0]  byte_in = 8'h00;
  logic        end_of_source = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [5:0]  token_kind;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [15:0] token_length;
  logic        bad_input;
  logic        last_of_run;
  logic        empty;
  logic        pop = 1'b0;

  source_text_tokenizer_core dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .end_of_source(end_of_source),
    .push(push),
    .full(full),
    .token_kind(token_kind),
    .line_number(line_number),
    .column_number(column_number),
    .token_length(token_length),
    .bad_input(bad_input),
    .last_of_run(last_of_run),
    .empty(empty),
    .pop(pop)
  );

  // The grave accent is handled apart so that it never sits in a literal.
  string specials_tail = "~!@#$%^&*-=+;:|,./?\n()[]{}<>";

  token_t      expected_tokens[$];
  token_t      step_tokens[$];
  logic [7:0]  src_text[$];
  bit          steady = 1'b0;
  int          mismatches = 0;
  int          tokens_checked = 0;
  int          bytes_sent = 0;
  int          sources_sent = 0;

  // Lexer state mirrored by the predictor.
  mode_t       lx_mode;
  bit          sof_done;
  bit          halted;
  logic [15:0] cur_line;
  logic [15:0] cur_col;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic [15:0] tok_len;
  bit          has_point;
  bit          after_bslash;
  logic [7:0]  word_head [WORD_KEEP];

  token_t      got_token;
  token_t      want_token;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic [7:0] special_char(int i);
    return (i == 0) ? CH_GRAVE : specials_tail[i-1];
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function void lexer_reset();
    lx_mode      = MODE_IDLE;
    sof_done     = 1'b0;
    halted       = 1'b0;
    cur_line     = 16'd1;
    cur_col      = 16'd1;
    tok_line     = 16'd0;
    tok_col      = 16'd0;
    tok_len      = 16'd0;
    has_point    = 1'b0;
    after_bslash = 1'b0;
  endfunction

  function void emit_token(logic [5:0] kind, logic [15:0] line, logic [15:0] col,
                           logic [15:0] len, logic bad);
    step_tokens.push_back({kind, line, col, len, bad, 1'b0});
  endfunction

  // Emits whatever token is still open. Literals that are still open at this
  // point were never terminated, so they are flagged bad.
  function void close_token();
    logic [87:0] packed_word;
    logic [5:0]  kind;
    int          kw;
    kw = -1;
    case (lx_mode)
      MODE_WORD: begin
        kind = KIND_WORD;
        if (tok_len <= WORD_KEEP) begin
          // Right-aligned, zero-padded; identifier bytes are never zero, so
          // the packed value alone decides both length and spelling.
          packed_word = '0;
          for (int i = 0; i < tok_len; i++)
            packed_word = {packed_word[79:0], word_head[i]};
          case (packed_word)
            "int":                       kw = 0;
            "float":                     kw = 1;
            "char":                      kw = 2;
            "string":                    kw = 3;
            "key":                       kw = 4;
            "bool":                      kw = 5;
            "defun":                     kw = 6;
            "return":                    kw = 7;
            88'h6d686b:                  kw = 8;
            88'h6d686b63:                kw = 9;
            "register":                  kw = 10;
            88'h6b65795f7072657373:      kw = 11;
            88'h6b65795f72656c65617365:  kw = 12;
            "init":                      kw = 13;
            "quit":                      kw = 14;
            "if":                        kw = 15;
            default:                     kw = -1;
          endcase
          if (kw >= 0)
            kind = KIND_KEY0 + kw[5:0];
        end
        emit_token(kind, tok_line, tok_col, tok_len, 1'b0);
      end
      MODE_NUM:
        emit_token(has_point ? KIND_FLOAT : KIND_INT, tok_line, tok_col, tok_len, 1'b0);
      MODE_STR:
        emit_token(KIND_STR, tok_line, tok_col, tok_len, 1'b1);
      MODE_CHR:
        emit_token(KIND_CHR, tok_line, tok_col, tok_len, 1'b1);
      default: ;
    endcase
    lx_mode = MODE_IDLE;
  endfunction

  // A byte that no open token takes starts a new one, is a special, is
  // skipped as blank, or stops the lexer as unknown.
  function void start_token(logic [7:0] b);
    int slot;
    slot = -1;
    tok_line     = cur_line;
    tok_col      = cur_col;
    tok_len      = 16'd1;
    has_point    = 1'b0;
    after_bslash = 1'b0;
    if (b == CH_DQUOTE) begin
      lx_mode = MODE_STR;
    end else if (b == CH_SQUOTE) begin
      lx_mode = MODE_CHR;
    end else if (is_digit(b)) begin
      lx_mode = MODE_NUM;
    end else if (is_alpha(b) || b == CH_UNDER) begin
      lx_mode = MODE_WORD;
      word_head[0] = b;
    end else if (b == 8'd9 || b == 8'd11 || b == 8'd12 || b == 8'd13 || b == CH_SPACE) begin
      tok_len = 16'd0;
    end else begin
      for (int i = 0; i < SPECIAL_TOTAL; i++)
        if (slot < 0 && special_char(i) == b)
          slot = i;
      if (slot >= 0) begin
        emit_token(KIND_PUNCT0 + slot[5:0], cur_line, cur_col, 16'd1, 1'b0);
      end else begin
        halted = 1'b1;
        emit_token(KIND_SOF, cur_line, cur_col, 16'd1, 1'b1);
      end
    end
  endfunction

  // Works out the results of one accepted byte and queues them.
  function void predict_byte(logic [7:0] b, logic eos);
    bit         taken;
    logic [7:0] quote;
    token_t     tail;
    taken = 1'b0;
    step_tokens = {};
    if (!sof_done) begin
      emit_token(KIND_SOF, 16'd0, 16'd0, 16'd0, 1'b0);
      sof_done = 1'b1;
    end
    if (!halted) begin
      case (lx_mode)
        MODE_WORD: begin
          if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
            if (tok_len < WORD_KEEP)
              word_head[tok_len] = b;
            tok_len = sat_inc(tok_len);
            taken = 1'b1;
          end else begin
            close_token();
          end
        end
        MODE_NUM: begin
          if (is_digit(b) || b == CH_POINT) begin
            if (b == CH_POINT)
              has_point = 1'b1;
            tok_len = sat_inc(tok_len);
            taken = 1'b1;
          end else begin
            close_token();
          end
        end
        MODE_STR, MODE_CHR: begin
          // The byte just before decides an escape; backslashes do not pair.
          quote = (lx_mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;
          tok_len = sat_inc(tok_len);
          taken = 1'b1;
          if (b == quote && !after_bslash) begin
            emit_token((lx_mode == MODE_STR) ? KIND_STR : KIND_CHR,
                       tok_line, tok_col, tok_len, 1'b0);
            lx_mode = MODE_IDLE;
          end
          after_bslash = (b == CH_BSLASH);
        end
        default: ;
      endcase
      if (!taken)
        start_token(b);
      if (b == CH_LF) begin
        cur_line = sat_inc(cur_line);
        cur_col  = 16'd1;
      end else begin
        cur_col = sat_inc(cur_col);
      end
    end
    if (eos) begin
      if (!halted)
        close_token();
      emit_token(KIND_EOF, 16'd0, 16'd0, 16'd0, 1'b0);
      lexer_reset();
    end
    if (step_tokens.size() > 0) begin
      tail = step_tokens.pop_back();
      tail.last = 1'b1;
      step_tokens.push_back(tail);
    end
    foreach (step_tokens[i])
      expected_tokens.push_back(step_tokens[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random pop, and a check of every popped token.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pop <= steady || ($urandom_range(99) >= 29);
  end

  function automatic void log_mismatch(string what, token_t want, token_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s", $time, what);
      $display("  expected kind %0d line %0d col %0d len %0d bad %0d last %0d",
               want.kind, want.line, want.col, want.len, want.bad, want.last);
      $display("  actual   kind %0d line %0d col %0d len %0d bad %0d last %0d",
               got.kind, got.line, got.col, got.len, got.bad, got.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      got_token = {token_kind, line_number, column_number, token_length, bad_input,
                   last_of_run};
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        log_mismatch("token with nothing expected", '0, got_token);
      end else begin
        want_token = expected_tokens.pop_front();
        if (got_token.kind !== want_token.kind || got_token.line !== want_token.line ||
            got_token.col !== want_token.col || got_token.len !== want_token.len ||
            got_token.bad !== want_token.bad || got_token.last !== want_token.last)
          log_mismatch("token mismatch", want_token, got_token);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // push stays high from one accepted request to the next unless a random gap
  // falls in between, so it never gets two updates in one time step.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!steady && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk);
    end
    byte_in       <= b;
    end_of_source <= eos;
    push          <= 1'b1;
    @(posedge clk);
    while (full)
      @(posedge clk);
    predict_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_source();
    for (int i = 0; i < src_text.size(); i++)
      send_byte(src_text[i], i == src_text.size() - 1);
    src_text = {};
    sources_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      src_text.push_back(s[i]);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [7:0] digit_char();
    logic [7:0] d;
    d = 8'($urandom_range(0, 9));
    return 8'h30 + d;
  endfunction

  function automatic logic [7:0] word_char(bit lead);
    logic [7:0] r;
    r = lead ? 8'($urandom_range(0, 52)) : 8'($urandom_range(0, 62));
    if (r < 26)
      return 8'h61 + r;
    if (r < 52)
      return 8'h41 + (r - 8'd26);
    if (r == 52)
      return CH_UNDER;
    return 8'h30 + (r - 8'd53);
  endfunction

  // Printable text with a fair share of backslashes and some linefeeds.
  function automatic logic [7:0] literal_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return CH_BSLASH;
    if (r < 15)
      return CH_LF;
    return 8'($urandom_range(32, 126));
  endfunction

  // Builds one source from well-formed tokens with random content, with a
  // little noise and the odd literal left open at the end.
  task automatic build_random_source();
    int         pieces;
    int         r;
    int         k;
    logic [7:0] q;
    pieces = $urandom_range(1, 12);
    repeat (pieces) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        k = $urandom_range(0, KEYWORD_TOTAL - 1);
        for (int i = 0; i < KW_LEN[k]; i++)
          src_text.push_back(KW_TEXT[k][8*KW_CAP-1-8*i -: 8]);
        // A trailing word character turns a keyword into a plain identifier, or into a longer keyword where one exists.
        if ($urandom_range(0, 4) == 0)
          src_text.push_back(word_char(1'b0));
      end else if (r < 24) begin
        src_text.push_back(word_char(1'b1));
        repeat ($urandom_range(0, 13))
          src_text.push_back(word_char(1'b0));
      end else if (r < 34) begin
        repeat ($urandom_range(1, 4))
          src_text.push_back(digit_char());
      end else if (r < 42) begin
        repeat ($urandom_range(1, 3))
          src_text.push_back(digit_char());
        src_text.push_back(CH_POINT);
        repeat ($urandom_range(0, 3))
          src_text.push_back(digit_char());
        if ($urandom_range(0, 4) == 0)
          src_text.push_back(CH_POINT);
      end else if (r < 58) begin
        q = (r < 52) ? CH_DQUOTE : CH_SQUOTE;
        src_text.push_back(q);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            src_text.push_back(CH_BSLASH);
            src_text.push_back(q);
          end else begin
            src_text.push_back(literal_char());
          end
        end
        src_text.push_back(q);
      end else if (r < 78) begin
        src_text.push_back(special_char(int'($urandom_range(0, SPECIAL_TOTAL - 1))));
      end else if (r < 88) begin
        case ($urandom_range(0, 4))
          0:       src_text.push_back(8'd9);
          1:       src_text.push_back(8'd11);
          2:       src_text.push_back(8'd12);
          3:       src_text.push_back(8'd13);
          default: src_text.push_back(CH_SPACE);
        endcase
      end else if (r < 93) begin
        src_text.push_back(CH_LF);
      end else begin
        src_text.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 1)
        src_text.push_back(CH_SPACE);
    end
    if ($urandom_range(0, 9) == 0) begin
      src_text.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
      repeat ($urandom_range(0, 3))
        src_text.push_back(literal_char());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Keyword, identifier with underscore and digits, float, string with an
  // escaped quote, char, special, linefeed, and an integer closed by the end
  // of the source.
  task automatic test_token_kinds();
    add_text("if _a9 3.1\"\\\"\"'c'+\n7");
    send_source();
  endtask

  // Unknown bytes at both ends of the byte range, bytes ignored while the
  // lexer is stopped, and a string and a char left open by the last byte.
  task automatic test_error_paths();
    src_text.push_back(8'h00);
    send_source();
    src_text.push_back(8'hFF);
    src_text.push_back(8'h61);
    src_text.push_back(CH_SPACE);
    send_source();
    add_text("\"ab");
    send_source();
    src_text.push_back(CH_SQUOTE);
    send_source();
  endtask

  task automatic test_random_sources();
    int first_byte;
    int batch;
    first_byte = bytes_sent;
    batch = 0;
    while (bytes_sent - first_byte < 330) begin
      build_random_source();
      // A stretch of sources with no gaps on either side.
      steady = (batch >= 4 && batch < 8);
      send_source();
      // Now and then the sender holds off until the block has caught up.
      if (batch % 7 == 6)
        drain_results();
      batch++;
    end
    steady = 1'b0;
  endtask

  initial begin
    lexer_reset();
    repeat (6)
      @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_token_kinds();
    test_error_paths();
    test_random_sources();
    drain_results();
    repeat (8)
      @(posedge clk);
    $display("Sent %0d sources with %0d bytes and checked %0d tokens.",
             sources_sent, bytes_sent, tokens_checked);
    $display("Covered each token kind, keywords, escapes, unknown bytes and open literals,");
    $display("under random stalls on both sides and a stretch with no stalls at all.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d tokens still expected", expected_tokens.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
